// File: sv/bmf_pkg.sv
// shared constants, types and helper functions of the 3x3 box mean filter
package bmf_pkg;

   // frame and pixel geometry
   localparam int MAX_SIZE  = 32;
   localparam int IDX_W     = $clog2(MAX_SIZE);
   localparam int SIZE_W    = 6;
   localparam int PIX_W     = 8;
   localparam int ROWS_KEPT = 3;
   localparam int SLOT_W    = 2;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

   // window sum and reciprocal divide
   localparam int SUM_W     = 12;
   localparam int RECIP_W   = 15;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam int DIV_SHIFT = 16;

   // neighbor count of a window
   typedef enum logic [1:0] {
      DIV_BY_4,
      DIV_BY_6,
      DIV_BY_9
   } div_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_MUL,
      ST_EMIT
   } ctrl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic                  wr_en;
      logic [SLOT_W-1:0]     wr_slot;
      logic [IDX_W-1:0]      wr_col;
      logic                  rd_en;
      logic                  rd_first;
      logic [IDX_W-1:0]      rd_col;
      logic                  col_ok;
      logic [ROWS_KEPT-1:0]  row_ok;
      logic                  mul_en;
      div_type               div_sel;
      logic                  out_load;
      logic                  out_last;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } dp_sts_type;

   // fixed point reciprocal, scaled by 2**DIV_SHIFT, exact for sums up to 9*255
   function automatic logic [RECIP_W-1:0] div_recip(input div_type sel);
      logic [RECIP_W-1:0] r;
      case (sel)
         DIV_BY_4: r = RECIP_W'(16384);
         DIV_BY_6: r = RECIP_W'(10923);
         DIV_BY_9: r = RECIP_W'(7282);
         default:  r = RECIP_W'(16384);
      endcase
      return r;
   endfunction

   // row slot arithmetic modulo three
   function automatic logic [SLOT_W-1:0] mod3_inc(input logic [SLOT_W-1:0] x);
      return (x == SLOT_W'(ROWS_KEPT - 1)) ? '0 : x + SLOT_W'(1);
   endfunction

   function automatic logic [SLOT_W-1:0] mod3_dec(input logic [SLOT_W-1:0] x);
      return (x == '0) ? SLOT_W'(ROWS_KEPT - 1) : x - SLOT_W'(1);
   endfunction

endpackage

// File: sv/bmf_req_if.sv
// pixel input channel
interface bmf_req_if;
   import bmf_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: sv/bmf_rsp_if.sv
// smoothed pixel output channel
interface bmf_rsp_if;
   import bmf_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// File: sv/bmf_csr_if.sv
// frame size register write channel
interface bmf_csr_if;
   import bmf_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] frame_size;

   modport source (output valid, output frame_size, input ready);
   modport sink   (input valid, input frame_size, output ready);
endinterface

// File: sv/box_mean_filter_3x3_core.sv
// top level of the 3x3 box mean filter
//
//   channel   dir   handshake       payload
//   req_bus   in    valid / ready   pixel_in   [7:0]
//   rsp_bus   out   valid / ready   pixel_out  [7:0], frame_end
//   csr_bus   in    valid / ready   frame_size [5:0]
//
// a word that yields no result is only written to its line buffer; otherwise each
// result passes through three line buffer column reads, sum, multiply and load
// the final word of a frame gives side + 2 results; the column reads of each result
// run in turn, set by the single read port of each line buffer
// reset is synchronous and active high; frame_size returns to 8, indices to zero
// a result waiting in the output register stalls the controller only at its next load
module box_mean_filter_3x3_core (
   input  logic      clock,
   input  logic      reset,
   bmf_req_if.sink   req_bus,
   bmf_rsp_if.source rsp_bus,
   bmf_csr_if.sink   csr_bus
);
   import bmf_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencing and frame bookkeeping
   bmf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .csr_valid      (csr_bus.valid),
      .csr_ready      (csr_bus.ready),
      .csr_frame_size (csr_bus.frame_size),
      .cmd            (cmd),
      .sts            (sts)
   );

   // line buffers and arithmetic
   bmf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .pixel_in  (req_bus.pixel_in),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .pixel_out (rsp_bus.pixel_out),
      .frame_end (rsp_bus.frame_end)
   );

endmodule

// File: sv/bmf_ram.sv
// generic single write port ram with registered read
module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bmf_datapath.sv
// line buffers, window accumulator, reciprocal divide and output register
module bmf_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  bmf_pkg::dp_cmd_type     cmd,
   output bmf_pkg::dp_sts_type     sts,
   input  logic [bmf_pkg::PIX_W-1:0] pixel_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [bmf_pkg::PIX_W-1:0] pixel_out,
   output logic                    frame_end
);
   import bmf_pkg::*;

   logic [PIX_W-1:0]     rd_data [ROWS_KEPT];
   logic                 rd_en_ff;
   logic                 rd_first_ff;
   logic                 col_ok_ff;
   logic [ROWS_KEPT-1:0] row_ok_ff;
   logic [SUM_W-1:0]     col_sum;
   logic [SUM_W-1:0]     acc_ff;
   logic [SUM_W-1:0]     acc_in;
   logic [PROD_W-1:0]    prod_ff;
   logic                 rsp_valid_ff;
   logic [PIX_W-1:0]     pixel_out_ff;
   logic                 frame_end_ff;

   // one line buffer per row slot, all read at the same column
   for (genvar j = 0; j < ROWS_KEPT; j++) begin : g_line
      bmf_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_SIZE)
      ) u_line (
         .clock   (clock),
         .wr_en   (cmd.wr_en && (cmd.wr_slot == SLOT_W'(j))),
         .wr_addr (cmd.wr_col),
         .wr_data (pixel_in),
         .rd_en   (cmd.rd_en),
         .rd_addr (cmd.rd_col),
         .rd_data (rd_data[j])
      );
   end

   // read qualifiers follow the ram latency
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_en_ff <= 1'b0;
      end else begin
         rd_en_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff <= cmd.rd_first;
      col_ok_ff   <= cmd.col_ok;
      row_ok_ff   <= cmd.row_ok;
   end

   // column sum of the in-frame rows
   always_comb begin
      col_sum = '0;
      for (int j = 0; j < ROWS_KEPT; j++) begin
         if (row_ok_ff[j]) begin
            col_sum = col_sum + SUM_W'(rd_data[j]);
         end
      end
      if (!col_ok_ff) begin
         col_sum = '0;
      end
      acc_in = (rd_first_ff ? '0 : acc_ff) + col_sum;
   end

   // window accumulator and reciprocal product
   always_ff @(posedge clock) begin
      if (rd_en_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(acc_ff) * PROD_W'(div_recip(cmd.div_sel));
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pixel_out_ff <= prod_ff[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
         frame_end_ff <= cmd.out_last;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign pixel_out    = pixel_out_ff;
   assign frame_end    = frame_end_ff;

endmodule

// File: sv/bmf_ctrl.sv
// controller: frame indices, result cursor and per result sequencing
module bmf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bmf_pkg::SIZE_W-1:0] csr_frame_size,
   output bmf_pkg::dp_cmd_type        cmd,
   input  bmf_pkg::dp_sts_type        sts
);
   import bmf_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0]  in_row_ff, in_row_in;
   logic [IDX_W-1:0]  in_col_ff, in_col_in;
   logic [SLOT_W-1:0] in_mod_ff, in_mod_in;
   logic [IDX_W-1:0]  cur_row_ff, cur_row_in;
   logic [IDX_W-1:0]  cur_col_ff, cur_col_in;
   logic [SLOT_W-1:0] cur_mod_ff, cur_mod_in;
   logic [IDX_W-1:0]  end_row_ff, end_row_in;
   logic [IDX_W-1:0]  end_col_ff, end_col_in;

   logic [SIZE_W-1:0] side;
   logic [IDX_W-1:0]  last;
   logic              row_edge;
   logic              col_edge;
   logic              csr_take;
   logic              req_take;

   // effective side length, clamped to the supported range
   always_comb begin
      if (size_ff < SIZE_MIN) begin
         side = SIZE_MIN;
      end else if (size_ff > SIZE_MAX) begin
         side = SIZE_MAX;
      end else begin
         side = size_ff;
      end
      last = IDX_W'(side - SIZE_W'(1));
   end

   // state and index registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         size_ff    <= SIZE_RESET;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         in_mod_ff  <= '0;
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         cur_mod_ff <= '0;
         end_row_ff <= '0;
         end_col_ff <= '0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         size_ff    <= size_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         in_mod_ff  <= in_mod_in;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         cur_mod_ff <= cur_mod_in;
         end_row_ff <= end_row_in;
         end_col_ff <= end_col_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      size_in    = size_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_mod_in  = in_mod_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      cur_mod_in = cur_mod_ff;
      end_row_in = end_row_ff;
      end_col_in = end_col_ff;

      cmd        = '0;
      cmd.div_sel = DIV_BY_4;

      csr_ready = (state_ff == ST_IDLE);
      req_ready = (state_ff == ST_IDLE) && !csr_valid;
      csr_take  = csr_valid && csr_ready;
      req_take  = req_valid && req_ready;

      row_edge = (cur_row_ff == '0) || (cur_row_ff == last);
      col_edge = (cur_col_ff == '0) || (cur_col_ff == last);

      // row slots of the window: above, center, below
      cmd.row_ok = '0;
      cmd.row_ok[cur_mod_ff] = 1'b1;
      if (cur_row_ff != '0) begin
         cmd.row_ok[mod3_dec(cur_mod_ff)] = 1'b1;
      end
      if (cur_row_ff != last) begin
         cmd.row_ok[mod3_inc(cur_mod_ff)] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_take) begin
               // new frame size drops the frame in progress
               size_in   = csr_frame_size;
               in_row_in = '0;
               in_col_in = '0;
               in_mod_in = '0;
            end else if (req_take) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_slot = in_mod_ff;
               cmd.wr_col  = in_col_ff;

               // results run over consecutive raster positions
               cur_row_in = in_row_ff - IDX_W'(1);
               cur_col_in = in_col_ff - IDX_W'(1);
               cur_mod_in = mod3_dec(in_mod_ff);
               if (in_row_ff == last && in_col_ff == last) begin
                  end_row_in = last;
                  end_col_in = last;
               end else if (in_col_ff == last) begin
                  end_row_in = in_row_ff - IDX_W'(1);
                  end_col_in = last;
               end else begin
                  end_row_in = in_row_ff - IDX_W'(1);
                  end_col_in = in_col_ff - IDX_W'(1);
               end
               if (in_row_ff != '0 && in_col_ff != '0) begin
                  state_in = ST_READ;
                  step_in  = '0;
               end

               // advance the input position
               if (in_col_ff == last) begin
                  in_col_in = '0;
                  if (in_row_ff == last) begin
                     in_row_in = '0;
                     in_mod_in = '0;
                  end else begin
                     in_row_in = in_row_ff + IDX_W'(1);
                     in_mod_in = mod3_inc(in_mod_ff);
                  end
               end else begin
                  in_col_in = in_col_ff + IDX_W'(1);
               end
            end
         end

         ST_READ: begin
            // one window column per cycle, left to right
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (step_ff == 2'd0);
            case (step_ff)
               2'd0: begin
                  cmd.rd_col = cur_col_ff - IDX_W'(1);
                  cmd.col_ok = (cur_col_ff != '0);
               end
               2'd1: begin
                  cmd.rd_col = cur_col_ff;
                  cmd.col_ok = 1'b1;
               end
               default: begin
                  cmd.rd_col = cur_col_ff + IDX_W'(1);
                  cmd.col_ok = (cur_col_ff != last);
               end
            endcase
            if (step_ff == 2'd2) begin
               state_in = ST_SUM;
               step_in  = '0;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end

         ST_SUM: begin
            state_in = ST_MUL;
         end

         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (row_edge && col_edge) begin
               cmd.div_sel = DIV_BY_4;
            end else if (row_edge || col_edge) begin
               cmd.div_sel = DIV_BY_6;
            end else begin
               cmd.div_sel = DIV_BY_9;
            end
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = (cur_row_ff == last) && (cur_col_ff == last);
               if (cur_row_ff == end_row_ff && cur_col_ff == end_col_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
                  step_in  = '0;
                  if (cur_col_ff == last) begin
                     cur_col_in = '0;
                     cur_row_in = cur_row_ff + IDX_W'(1);
                     cur_mod_in = mod3_inc(cur_mod_ff);
                  end else begin
                     cur_col_in = cur_col_ff + IDX_W'(1);
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
